@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each check is clocked on clk and
// held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ src/cgvt_pkg.sv @@
package cgvt_pkg;

    // Register file
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DISC_W     = 17;

    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACE_DECAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RHO_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRACE_LIMIT = 2'd3;

    localparam logic [DISC_W-1:0]     DISCOUNT_RST    = 17'd64881;
    localparam logic [DISC_W-1:0]     TRACE_DECAY_RST = 17'd62259;
    localparam logic [CFG_DATA_W-1:0] RHO_LIMIT_RST   = 32'd65536;
    localparam logic [CFG_DATA_W-1:0] TRACE_LIMIT_RST = 32'd65536;

    // Shared multiplier: 32-bit unsigned by 33-bit signed
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
    localparam int SUM_W   = PROD_W + 1;

    // Sequencer
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [1:0] {
        A_DISC,
        A_GL,
        A_RHO,
        A_COEF
    } mul_a_t;

    typedef enum logic [2:0] {
        B_TD,
        B_LVAL,
        B_C,
        B_INNER,
        B_ACC
    } mul_b_t;

    // Writeback of the previous step's product, or result delivery
    typedef enum logic [2:0] {
        WB_NONE,
        WB_GL,
        WB_INNER,
        WB_COEF,
        WB_DELTA,
        WB_ACC,
        WB_EMIT,
        WB_START
    } wb_t;

    typedef struct packed {
        mul_a_t mul_a;
        mul_b_t mul_b;
        wb_t    wb;
        logic   br_start;
        step_t  target;
        logic   last;
    } ctrl_t;

    localparam step_t STEP_START = 3'd7;

    // Control store
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t c;
        c = '{mul_a: A_DISC, mul_b: B_TD, wb: WB_NONE, br_start: 1'b0,
              target: '0, last: 1'b0};
        unique case (step)
            3'd0: begin
                c.mul_a    = A_DISC;
                c.mul_b    = B_TD;
                c.br_start = 1'b1;
                c.target   = STEP_START;
            end
            3'd1: begin
                c.mul_a = A_DISC;
                c.mul_b = B_LVAL;
                c.wb    = WB_GL;
            end
            3'd2: begin
                c.mul_a = A_GL;
                c.mul_b = B_C;
                c.wb    = WB_INNER;
            end
            3'd3: begin
                c.mul_a = A_RHO;
                c.mul_b = B_INNER;
                c.wb    = WB_COEF;
            end
            3'd4: begin
                c.mul_a = A_COEF;
                c.mul_b = B_ACC;
                c.wb    = WB_DELTA;
            end
            3'd5: begin
                c.wb = WB_ACC;
            end
            3'd6: begin
                c.wb   = WB_EMIT;
                c.last = 1'b1;
            end
            3'd7: begin
                c.wb   = WB_START;
                c.last = 1'b1;
            end
        endcase
        return c;
    endfunction

    // Clamp a wide signed sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
        logic [SUM_W-32:0] top;
        logic signed [31:0] r;
        top = x[SUM_W-1:31];
        if (top == '0 || top == '1) begin
            r = x[31:0];
        end else if (x[SUM_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

@@ src/clipped_gae_vtrace_scan.sv @@
// Reverse-time clipped GAE / V-trace scan in signed fixed point with FRAC_BITS
// fraction bits. Feed a row last step first, with row_start set on that item.
// One item is in flight at a time: the next is taken once the control program,
// which runs all five products of the recurrence through one registered 33x33
// multiplier, has delivered the previous item's result; a row-start item
// branches from step 0 to its delivery step. A finished result sits in an output
// register, so in_stall drops while out_valid waits; a program reaching its
// delivery step while the previous result is still stalled holds there.
// Configuration writes are taken in any cycle but belong to idle periods.
`include "assert_macros.svh"

module clipped_gae_vtrace_scan #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [cgvt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cgvt_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [31:0]                   value_est,
    input  logic signed [31:0]                   reward,
    input  logic                                 episode_done,
    input  logic [31:0]                          ratio,
    input  logic                                 row_start,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [31:0]                   advantage,
    output logic signed [31:0]                   target_value,
    output logic                                 advantage_valid
);
    import cgvt_pkg::*;

    localparam int GL_W = 2 * DISC_W - FRAC_BITS;

    // Configuration
    logic [DISC_W-1:0]     discount_reg;
    logic [DISC_W-1:0]     trace_decay_reg;
    logic [CFG_DATA_W-1:0] rho_limit_reg;
    logic [CFG_DATA_W-1:0] trace_limit_reg;

    // Sequencer
    logic  busy_reg;
    logic  busy_next;
    step_t step_reg;
    step_t step_next;
    ctrl_t ctrl;

    // Scan state
    logic signed [31:0] acc_reg;
    logic signed [31:0] later_value_reg;
    logic signed [31:0] later_reward_reg;
    logic               later_done_reg;

    // Item held during the program
    logic signed [31:0] in_value_reg;
    logic signed [31:0] in_reward_reg;
    logic               in_done_reg;
    logic [31:0]        in_ratio_reg;
    logic               in_start_reg;

    // Scratch
    logic [GL_W-1:0]    gl_reg;
    logic signed [31:0] inner_reg;
    logic [31:0]        coef_reg;
    logic signed [31:0] delta_reg;

    // Output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] advantage_reg;
    logic signed [31:0] target_reg;
    logic               adv_valid_reg;

    // Datapath
    logic [MUL_A_W-1:0]        mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [SUM_W-1:0]   decay_x;
    logic signed [SUM_W-1:0]   inner_sum;
    logic signed [SUM_W-1:0]   acc_sum;
    logic signed [SUM_W-1:0]   tgt_sum;
    logic                      coef_ovf;
    logic [31:0]               rho;
    logic [31:0]               clip_c;
    logic                      accept;
    logic                      out_free;
    logic                      emit_step;
    logic                      emit_fire;

    assign ctrl      = ucode(step_reg);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_step = busy_reg && (ctrl.wb == WB_EMIT || ctrl.wb == WB_START);
    assign emit_fire = emit_step && out_free;

    // Clip the ratio by both limits
    assign rho    = (in_ratio_reg < rho_limit_reg) ? in_ratio_reg : rho_limit_reg;
    assign clip_c = (in_ratio_reg < trace_limit_reg) ? in_ratio_reg : trace_limit_reg;

    // Select multiplier operands
    always_comb
    begin
        unique case (ctrl.mul_a)
            A_DISC:  mul_a = MUL_A_W'(discount_reg);
            A_GL:    mul_a = MUL_A_W'(gl_reg);
            A_RHO:   mul_a = rho;
            A_COEF:  mul_a = coef_reg;
            default: mul_a = MUL_A_W'(discount_reg);
        endcase
        unique case (ctrl.mul_b)
            B_TD:    mul_b = $signed(MUL_B_W'(trace_decay_reg));
            B_LVAL:  mul_b = {later_value_reg[31], later_value_reg};
            B_C:     mul_b = $signed({1'b0, clip_c});
            B_INNER: mul_b = {inner_reg[31], inner_reg};
            B_ACC:   mul_b = {acc_reg[31], acc_reg};
            default: mul_b = $signed(MUL_B_W'(trace_decay_reg));
        endcase
    end

    cgvt_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Floor-shift the product; drop the later-step term after an episode end
    assign prod_sh   = prod >>> FRAC_BITS;
    assign decay_x   = later_done_reg ? '0 : {prod_sh[PROD_W-1], prod_sh};
    assign inner_sum = {{(SUM_W-32){later_reward_reg[31]}}, later_reward_reg} + decay_x
                     - {{(SUM_W-32){in_value_reg[31]}}, in_value_reg};
    assign acc_sum   = {{(SUM_W-32){delta_reg[31]}}, delta_reg} + decay_x;
    assign tgt_sum   = {{(SUM_W-32){acc_reg[31]}}, acc_reg}
                     + {{(SUM_W-32){in_value_reg[31]}}, in_value_reg};
    assign coef_ovf  = |prod[PROD_W-1:FRAC_BITS+32];

    // Advance the program
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg) begin
            if (accept) begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end else if (emit_step && !out_free) begin
            step_next = step_reg;
        end else if (ctrl.last) begin
            busy_next = 1'b0;
        end else if (ctrl.br_start && in_start_reg) begin
            step_next = ctrl.target;
        end else begin
            step_next = step_reg + step_t'(1);
        end
    end

    // Hold a result until taken
    always_comb
    begin
        if (emit_fire) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg         <= 1'b0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
            discount_reg     <= DISCOUNT_RST;
            trace_decay_reg  <= TRACE_DECAY_RST;
            rho_limit_reg    <= RHO_LIMIT_RST;
            trace_limit_reg  <= TRACE_LIMIT_RST;
            acc_reg          <= '0;
            later_value_reg  <= '0;
            later_reward_reg <= '0;
            later_done_reg   <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_DISCOUNT:    discount_reg    <= cfg_data[DISC_W-1:0];
                    REG_TRACE_DECAY: trace_decay_reg <= cfg_data[DISC_W-1:0];
                    REG_RHO_LIMIT:   rho_limit_reg   <= cfg_data;
                    REG_TRACE_LIMIT: trace_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (busy_reg && ctrl.wb == WB_ACC) begin
                acc_reg <= sat32(acc_sum);
            end
            if (emit_fire) begin
                if (ctrl.wb == WB_START) begin
                    acc_reg <= '0;
                end
                later_value_reg  <= in_value_reg;
                later_reward_reg <= in_reward_reg;
                later_done_reg   <= in_done_reg;
            end
        end
    end

    // Item capture, scratch and output payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            in_value_reg  <= value_est;
            in_reward_reg <= reward;
            in_done_reg   <= episode_done;
            in_ratio_reg  <= ratio;
            in_start_reg  <= row_start;
        end
        if (busy_reg) begin
            unique case (ctrl.wb)
                WB_GL:    gl_reg    <= prod[FRAC_BITS +: GL_W];
                WB_INNER: inner_reg <= sat32(inner_sum);
                WB_COEF:  coef_reg  <= coef_ovf ? '1 : prod[FRAC_BITS +: 32];
                WB_DELTA: delta_reg <= sat32({prod_sh[PROD_W-1], prod_sh});
                default: ;
            endcase
        end
        if (emit_fire) begin
            if (ctrl.wb == WB_START) begin
                advantage_reg <= '0;
                target_reg    <= in_value_reg;
                adv_valid_reg <= 1'b0;
            end else begin
                advantage_reg <= acc_reg;
                target_reg    <= sat32(tgt_sum);
                adv_valid_reg <= 1'b1;
            end
        end
    end

    assign in_stall        = busy_reg;
    assign out_valid       = out_valid_reg;
    assign advantage       = advantage_reg;
    assign target_value    = target_reg;
    assign advantage_valid = adv_valid_reg;

    // Checks
    `ASSERT_NEXT(a_accept_starts, accept, busy_reg && step_reg == '0,
        "accepted item did not start the program at step zero")
    `ASSERT_IMP(a_result_from_emit, $rose(out_valid_reg),
        $past(busy_reg) && ($past(ctrl.wb) == WB_EMIT || $past(ctrl.wb) == WB_START),
        "result appeared outside a delivery step")
    `ASSERT_IMP(a_done_delivers, $fell(busy_reg), out_valid_reg,
        "program ended without delivering its result")
    `ASSERT_IMP(a_row_start_zero, out_valid_reg && !adv_valid_reg, advantage_reg == '0,
        "row-start result carries a nonzero advantage")

endmodule

@@ src/cgvt_mul.sv @@
module cgvt_mul (
    input  logic                                clk,
    input  logic        [cgvt_pkg::MUL_A_W-1:0] a,
    input  logic signed [cgvt_pkg::MUL_B_W-1:0] b,
    output logic signed [cgvt_pkg::PROD_W-1:0]  prod
);
    import cgvt_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // Multiply unsigned a by signed b
    assign prod_next = $signed({1'b0, a}) * b;

    // Register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
